// ----- rtl/huffman_table_encoder_unit_macros.svh -----
// Assertion macros shared by the Huffman encoder RTL
`ifndef HUFFMAN_TABLE_ENCODER_UNIT_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, needs clk and arst_n in scope
`define HTE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hte_pkg.sv -----
// Types, constants and codes shared by the Huffman encoder modules
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;

	localparam int KIND_W = 2;
	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 24;
	localparam int ST_W   = 2;
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;

	localparam int IDX_W   = $clog2(SYMBOL_COUNT);
	localparam int WIN_W   = CODE_W + BYTE_W;
	localparam int MAX_RES = (MAX_CODE_LEN + BYTE_W - 1) / BYTE_W;
	localparam int NB_W    = $clog2(MAX_RES + 1);
	localparam int AV_W    = $clog2(MAX_RES + 2);
	localparam int TOT_W   = LEN_W + 1;
	localparam int SEL_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
	localparam int Q_DEPTH = 4;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	localparam logic [CNT_W-1:0] LIMIT_RST = {CNT_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIN  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} hte_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_last;
		logic [ST_W-1:0]   status;
		logic [CNT_W-1:0]  byte_count;
	} hte_out_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} hte_entry_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} hte_wr_t;

	// group of result words produced by one item
	typedef struct packed {
		logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
		logic [NB_W-1:0]                n;
		logic                           last;
		logic [ST_W-1:0]                status;
		logic [CNT_W-1:0]               count;
	} hte_grp_t;

endpackage

`default_nettype wire

// ----- rtl/hte_table.sv -----
// Code table memory with per-entry valid bits and registered read
`timescale 1ns / 1ps
`default_nettype none

module hte_table (
	input  wire                     clk,
	input  wire                     arst_n,
	input  hte_pkg::hte_wr_t        wr,
	input  wire                     rd_en,
	input  wire [hte_pkg::IDX_W-1:0] rd_addr,
	output hte_pkg::hte_entry_t     rd
);
	import hte_pkg::*;

	hte_entry_t              mem [SYMBOL_COUNT];
	hte_entry_t              ent_q;
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= '{len: wr.len, code: wr.code};
		end
		if (rd_en) begin
			ent_q <= mem[rd_addr];
		end
	end

	// length of an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd.len  = rd_vld_q ? ent_q.len : '0;
	assign rd.code = ent_q.code;

endmodule

`default_nettype wire

// ----- rtl/hte_packer.sv -----
// Bit packer stage: stream state, limit register and result group build
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_table_encoder_unit_macros.svh"

module hte_packer (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [hte_pkg::CNT_W-1:0]   cfg_wdata,
	input  wire                        in_acc,
	input  wire [hte_pkg::KIND_W-1:0]  in_kind,
	input  wire                        in_sym_ok,
	input  hte_pkg::hte_entry_t        rd,
	input  wire                        q_full,
	output logic                       in_ready,
	output logic                       push,
	output hte_pkg::hte_grp_t          grp
);
	import hte_pkg::*;

	logic               s1_vld_q;
	logic [KIND_W-1:0]  kind_s1;
	logic               sym_ok_s1;

	logic [CNT_W-1:0]   limit_q;
	logic [PEND_W-1:0]  pend_q;
	logic [PCNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic               err_q;
	logic [ST_W-1:0]    err_kind_q;

	logic               go;
	logic               is_enc;
	logic               is_fin;
	logic [LEN_W-1:0]   clen;
	logic [TOT_W-1:0]   total;
	logic [NB_W-1:0]    nb;
	logic [PCNT_W-1:0]  rem;
	logic [CNT_W-1:0]   diff;
	logic [AV_W-1:0]    avail;
	logic               full_err;
	logic [NB_W-1:0]    k;
	logic [PEND_W-1:0]  pend_la;
	logic [CODE_W-1:0]  code_la;
	logic [WIN_W-1:0]   win;
	logic [WIN_W-1:0]   win_sh;
	logic [PEND_W-1:0]  new_pend;
	logic [BYTE_W-1:0]  fin_byte;
	logic [CNT_W-1:0]   fin_count;

	assign go       = s1_vld_q && !q_full;
	assign in_ready = !s1_vld_q || !q_full;
	assign is_enc   = kind_s1 == KIND_ENC;
	assign is_fin   = kind_s1 == KIND_FIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_acc) begin
			s1_vld_q <= 1'b1;
		end else if (go) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1   <= in_kind;
			sym_ok_s1 <= in_sym_ok;
		end
	end

	always_comb begin
		clen   = sym_ok_s1 ? rd.len : '0;
		total  = TOT_W'(cnt_q) + TOT_W'(clen);
		nb     = NB_W'(total >> 3);
		rem    = total[PCNT_W-1:0];
		diff   = limit_q - idx_q;
		if (limit_q <= idx_q) begin
			avail = '0;
		end else if (diff > CNT_W'(MAX_RES)) begin
			avail = AV_W'(MAX_RES + 1);
		end else begin
			avail = AV_W'(diff);
		end
		full_err = total > TOT_W'({avail, 3'b000});
		k        = full_err ? NB_W'(avail) : nb;

		// pending bits then code bits, left aligned
		pend_la  = pend_q << (PCNT_W'(PEND_W) - cnt_q);
		code_la  = rd.code << (LEN_W'(CODE_W) - clen);
		win      = {pend_la, {(WIN_W - PEND_W){1'b0}}}
			| ({code_la, {BYTE_W{1'b0}}} >> cnt_q);
		win_sh   = win << {nb, 3'b000};
		new_pend = win_sh[WIN_W-1 -: PEND_W] >> (PCNT_W'(PEND_W) - rem);

		fin_byte  = BYTE_W'({1'b0, pend_q} << (4'd8 - {1'b0, cnt_q}));
		fin_count = idx_q + CNT_W'(cnt_q != '0);

		for (int j = 0; j < MAX_RES; j++) begin
			grp.bytes[j] = win[WIN_W-1-BYTE_W*j -: BYTE_W];
		end
		if (is_fin) begin
			grp.bytes[0] = (err_q || cnt_q == '0) ? '0 : fin_byte;
		end
		grp.n      = is_fin ? NB_W'(1) : k;
		grp.last   = is_fin;
		grp.status = (is_fin && err_q) ? err_kind_q : ST_OK;
		grp.count  = (is_fin && !err_q) ? fin_count : '0;

		push = go && (is_fin || (is_enc && !err_q && clen != '0 && k != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			cnt_q      <= '0;
			idx_q      <= '0;
			err_q      <= 1'b0;
			err_kind_q <= ST_OK;
		end else if (go) begin
			if (is_fin) begin
				pend_q     <= '0;
				cnt_q      <= '0;
				idx_q      <= '0;
				err_q      <= 1'b0;
				err_kind_q <= ST_OK;
			end else if (is_enc && !err_q) begin
				if (clen == '0) begin
					err_q      <= 1'b1;
					err_kind_q <= ST_UNKNOWN;
				end else begin
					pend_q <= new_pend;
					cnt_q  <= rem;
					idx_q  <= idx_q + CNT_W'(k);
					if (full_err) begin
						err_q      <= 1'b1;
						err_kind_q <= ST_FULL;
					end
				end
			end
		end
	end

	`HTE_ASSERT_IMPL(a_err_blocks_enc, s1_vld_q && is_enc && err_q, !push, "encode output with error held")
	`HTE_ASSERT_NEXT(a_fin_clears, go && is_fin, idx_q == '0 && cnt_q == '0 && !err_q, "finish did not clear stream state")
	`HTE_ASSERT_IMPL(a_grp_size, push, grp.n != '0 && grp.n <= NB_W'(MAX_RES), "bad group size")

endmodule

`default_nettype wire

// ----- rtl/hte_out_queue.sv -----
// Result group queue and serializer onto the output channel
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_table_encoder_unit_macros.svh"

module hte_out_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  hte_pkg::hte_grp_t   grp,
	output logic                full,
	output logic                out_valid,
	input  wire                 out_ready,
	output hte_pkg::hte_out_t   out_data
);
	import hte_pkg::*;

	hte_grp_t          q_regs_q [Q_DEPTH];
	hte_grp_t          head;
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   cnt_q;
	logic [SEL_W-1:0]  sel_q;
	logic              take;
	logic              last_word;
	logic              pop;

	assign head      = q_regs_q[rd_ptr_q];
	assign full      = cnt_q == QC_W'(Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign take      = out_valid && out_ready;
	assign last_word = (NB_W'(sel_q) + NB_W'(1)) == head.n;
	assign pop       = take && last_word;

	assign out_data.out_byte   = head.bytes[sel_q];
	assign out_data.is_last    = head.last;
	assign out_data.status     = head.status;
	assign out_data.byte_count = head.count;

	always_ff @(posedge clk) begin
		if (push) begin
			q_regs_q[wr_ptr_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sel_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QP_W'(1);
				sel_q    <= '0;
			end else if (take) begin
				sel_q <= sel_q + SEL_W'(1);
			end
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(pop);
		end
	end

	`HTE_ASSERT_IMPL(a_sel_in_group, out_valid, NB_W'(sel_q) < head.n, "word select past group end")
	`HTE_ASSERT_IMPL(a_no_overflow, full, !push, "push into full queue")

endmodule

`default_nettype wire

// ----- rtl/huffman_table_encoder_unit.sv -----
// Top level of the table-driven Huffman encoder
//
// channel  | signals                      | dir | word
// ---------+------------------------------+-----+----------------------------------
// input    | in_valid in_ready in_data    | in  | kind symbol code_word code_length
// output   | out_valid out_ready out_data | out | out_byte is_last status byte_count
// config   | cfg_we cfg_wdata             | in  | output_limit, no wait
//
// One input word per cycle while in_ready is high; an item reaches the packer in
// the cycle after acceptance (table memory read). An encode yielding n bytes gives
// n output words; a four-group queue absorbs bursts, input stalls only when full.
// Reset is immediate: the length table is cleared through per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_encoder_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  hte_pkg::hte_in_t          in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output hte_pkg::hte_out_t         out_data,
	input  wire                       cfg_we,
	input  wire [hte_pkg::CNT_W-1:0]  cfg_wdata
);
	import hte_pkg::*;

	logic        in_acc;
	logic        sym_ok;
	hte_wr_t     tbl_wr;
	hte_entry_t  tbl_rd;
	logic        q_full;
	logic        push;
	hte_grp_t    grp;

	assign in_acc = in_valid && in_ready;
	assign sym_ok = {1'b0, in_data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);

	assign tbl_wr.en   = in_acc && in_data.kind == KIND_LOAD && sym_ok;
	assign tbl_wr.addr = in_data.symbol[IDX_W-1:0];
	assign tbl_wr.len  = (in_data.code_length > LEN_W'(MAX_CODE_LEN))
		? LEN_W'(MAX_CODE_LEN) : in_data.code_length;
	assign tbl_wr.code = in_data.code_word;

	hte_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_en   (in_acc),
		.rd_addr (in_data.symbol[IDX_W-1:0]),
		.rd      (tbl_rd)
	);

	hte_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_acc    (in_acc),
		.in_kind   (in_data.kind),
		.in_sym_ok (sym_ok),
		.rd        (tbl_rd),
		.q_full    (q_full),
		.in_ready  (in_ready),
		.push      (push),
		.grp       (grp)
	);

	hte_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.grp       (grp),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- dv/huffman_table_encoder_unit_tb.sv -----
// Self-checking testbench for the table-driven Huffman encoder unit
`timescale 1ns / 1ps

module huffman_table_encoder_unit_tb;
	import hte_pkg::*;

	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
	localparam logic [LEN_W-1:0]  LEN_CAP  = LEN_W'(MAX_CODE_LEN);
	localparam int                CYCLE_LIMIT = 200000;
	localparam int                DRAIN_CYCLES = 8;
	localparam int                HOLD_CYCLES = 250;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	hte_in_t          in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	hte_out_t         out_data;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// encoder state as the testbench sees it
	logic [CODE_W-1:0] tab_code [SYMBOL_COUNT];
	logic [LEN_W-1:0]  tab_len [SYMBOL_COUNT];
	logic [PEND_W-1:0] acc_bits = '0;
	logic [PCNT_W-1:0] acc_cnt = '0;
	logic [CNT_W-1:0]  bytes_out = '0;
	logic              err_held = 1'b0;
	logic [ST_W-1:0]   err_code = ST_OK;
	logic [CNT_W-1:0]  limit_reg = LIMIT_RST;

	hte_out_t    coded_words [$];
	logic [7:0]  known_syms [$];

	int cycles = 0;
	int fails = 0;
	int words_checked = 0;
	int items_sent = 0;
	int hold_req = 0;
	int stall_left = 0;
	int rx_pick;
	bit calm = 1'b0;

	huffman_table_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("huffman_table_encoder_unit_tb: errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < SYMBOL_COUNT; i++) begin
			tab_len[i] = '0;
			tab_code[i] = '0;
		end
	end

	function automatic hte_out_t mk_word(input logic [BYTE_W-1:0] b, input logic l,
			input logic [ST_W-1:0] s, input logic [CNT_W-1:0] c);
		hte_out_t w;
		w.out_byte = b;
		w.is_last = l;
		w.status = s;
		w.byte_count = c;
		return w;
	endfunction

	function automatic hte_in_t item(input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s,
			input logic [CODE_W-1:0] cw, input logic [LEN_W-1:0] cl);
		hte_in_t w;
		w.kind = k;
		w.symbol = s;
		w.code_word = cw;
		w.code_length = cl;
		return w;
	endfunction

	// advance the encoder state by one accepted word and queue the bytes it yields
	task automatic run_packer(input hte_in_t w);
		int unsigned       clen;
		int unsigned       cnt;
		logic [BYTE_W-1:0] acc;
		logic [CODE_W-1:0] code;
		logic [BYTE_W-1:0] pad;
		logic [CNT_W-1:0]  total;
		case (w.kind)
			KIND_LOAD: begin
				tab_code[w.symbol] = w.code_word;
				tab_len[w.symbol] = (w.code_length > LEN_CAP) ? LEN_CAP : w.code_length;
			end
			KIND_ENC: begin
				if (!err_held) begin
					clen = 32'(tab_len[w.symbol]);
					if (clen == 0) begin
						err_held = 1'b1;
						err_code = ST_UNKNOWN;
					end else begin
						code = tab_code[w.symbol];
						acc = {1'b0, acc_bits};
						cnt = 32'(acc_cnt);
						while (clen > 0) begin
							clen--;
							if (bytes_out >= limit_reg) begin
								err_held = 1'b1;
								err_code = ST_FULL;
								break;
							end
							acc = {acc[BYTE_W-2:0], code[clen]};
							cnt++;
							if (cnt == BYTE_W) begin
								coded_words.push_back(mk_word(acc, 1'b0, ST_OK, '0));
								bytes_out = bytes_out + 1'b1;
								acc = '0;
								cnt = 0;
							end
						end
						acc_bits = acc[PEND_W-1:0];
						acc_cnt = cnt[PCNT_W-1:0];
					end
				end
			end
			KIND_FIN: begin
				if (err_held) begin
					coded_words.push_back(mk_word('0, 1'b1, err_code, '0));
				end else begin
					pad = '0;
					total = bytes_out;
					if (acc_cnt != 0) begin
						pad = {1'b0, acc_bits};
						pad = pad << (BYTE_W - acc_cnt);
						total = total + 1'b1;
					end
					coded_words.push_back(mk_word(pad, 1'b1, ST_OK, total));
				end
				acc_bits = '0;
				acc_cnt = '0;
				bytes_out = '0;
				err_held = 1'b0;
				err_code = ST_OK;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (coded_words.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("cycle %0d: word with nothing due: byte %02h last %0b st %0d cnt %0d",
						cycles, out_data.out_byte, out_data.is_last, out_data.status,
						out_data.byte_count);
			end else begin
				words_checked++;
				if (out_data !== coded_words[0]) begin
					fails++;
					if (fails <= 10)
						$display("cycle %0d: want %02h/%0b/%0d/%0d got %02h/%0b/%0d/%0d",
							cycles,
							coded_words[0].out_byte, coded_words[0].is_last,
							coded_words[0].status, coded_words[0].byte_count,
							out_data.out_byte, out_data.is_last, out_data.status,
							out_data.byte_count);
				end
				void'(coded_words.pop_front());
			end
		end
	end

	// output side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = (rx_pick >= 96) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(input hte_in_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		run_packer(w);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (coded_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CNT_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_reg = v;
	endtask

	task automatic test_empty_and_unknown();
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		send_word(item(KIND_ENC, 8'h5A, '1, '1));
		send_word(item(KIND_ENC, 8'h5A, '0, '0));
		send_word(item(KIND_FIN, 8'hA5, '1, '1));
		send_word(item(KIND_NOP, 8'hFF, '1, '1));
	endtask

	task automatic test_table_extremes();
		send_word(item(KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32));
		send_word(item(KIND_LOAD, 8'hFF, 32'hFFFF_FFFE, 6'd1));
		send_word(item(KIND_LOAD, 8'h81, 32'h2AAA_AAAA, 6'd63));
		send_word(item(KIND_LOAD, 8'h7E, 32'h0000_0005, 6'd3));
		send_word(item(KIND_ENC, 8'hFF, '0, '0));
		send_word(item(KIND_ENC, 8'h00, '0, '0));
		send_word(item(KIND_ENC, 8'h81, '0, '0));
		send_word(item(KIND_ENC, 8'h7E, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		send_word(item(KIND_LOAD, 8'h7E, 32'h0000_0005, 6'd0));
		send_word(item(KIND_ENC, 8'h00, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		send_word(item(KIND_ENC, 8'h7E, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
	endtask

	task automatic test_output_full();
		set_limit('0);
		send_word(item(KIND_ENC, 8'h00, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		set_limit(24'd2);
		send_word(item(KIND_ENC, 8'h81, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		set_limit(LIMIT_RST);
		send_word(item(KIND_ENC, 8'h00, '0, '0));
		// lower the limit below the bytes already sent, mid-stream
		set_limit(24'd2);
		send_word(item(KIND_ENC, 8'hFF, '0, '0));
		send_word(item(KIND_FIN, 8'h00, '0, '0));
		set_limit(LIMIT_RST);
	endtask

	task automatic test_output_stall();
		logic [SYM_W-1:0] s;
		s = SYM_W'($urandom);
		send_word(item(KIND_LOAD, s, $urandom, LEN_CAP));
		wait_idle();
		calm = 1'b1;
		@(posedge clk);
		hold_req = HOLD_CYCLES;
		repeat (14) send_word(item(KIND_ENC, s, $urandom, LEN_W'($urandom)));
		send_word(item(KIND_FIN, s, '0, '0));
		wait_idle();
		calm = 1'b0;
	endtask

	function automatic logic [LEN_W-1:0] rand_len();
		int q;
		q = $urandom_range(0, 99);
		if (q < 4)
			return '0;
		if (q < 60)
			return LEN_W'($urandom_range(1, 8));
		if (q < 85)
			return LEN_W'($urandom_range(9, 24));
		if (q < 95)
			return LEN_W'($urandom_range(25, 32));
		return LEN_W'($urandom_range(33, 63));
	endfunction

	function automatic hte_in_t rand_item();
		int               r;
		logic [SYM_W-1:0] s;
		hte_in_t          w;
		r = $urandom_range(0, 99);
		s = known_syms[$urandom_range(0, known_syms.size() - 1)];
		w = item(KIND_ENC, s, $urandom, LEN_W'($urandom));
		if (r >= 64 && r < 78) begin
			w = item(KIND_LOAD, SYM_W'($urandom), $urandom, rand_len());
			if (w.code_length != 0)
				known_syms.push_back(w.symbol);
		end else if (r >= 78 && r < 88) begin
			w.kind = KIND_FIN;
		end else if (r >= 88 && r < 96) begin
			w.symbol = SYM_W'($urandom);
		end else if (r >= 96) begin
			w.kind = KIND_NOP;
		end
		return w;
	endfunction

	task automatic test_random_streams();
		logic [CNT_W-1:0] lims [4];
		int               quota [4];
		int               n;
		hte_in_t          w;
		lims[0] = LIMIT_RST;
		lims[1] = CNT_W'($urandom_range(2, 12));
		lims[2] = CNT_W'($urandom_range(13, 60));
		lims[3] = '0;
		quota[0] = 16;
		quota[1] = 16;
		quota[2] = 16;
		quota[3] = 7;
		repeat (10) begin
			w = item(KIND_LOAD, SYM_W'($urandom), $urandom, LEN_W'($urandom_range(1, 16)));
			known_syms.push_back(w.symbol);
			send_word(w);
		end
		for (int p = 0; p < 4; p++) begin
			set_limit(lims[p]);
			calm = (p == 2);
			n = 0;
			while (n < quota[p]) begin
				w = rand_item();
				send_word(w);
				if (w.kind != KIND_NOP)
					n++;
			end
		end
		calm = 1'b0;
		send_word(item(KIND_FIN, '0, '0, '0));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_and_unknown();
		test_table_extremes();
		test_output_full();
		test_output_stall();
		test_random_streams();
		wait_idle();
		if (coded_words.size() != 0)
			fails++;
		$display("%0d items in, %0d words checked; limits 0, small and max,", items_sent,
			words_checked);
		$display("unknown-symbol and output-full errors, and a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (fails == 0)
			$display("huffman_table_encoder_unit_tb: clean");
		else
			$display("huffman_table_encoder_unit_tb: errors");
		$finish;
	end

endmodule
